[rtl/crd_pkg.sv]
// ----------------------------------------------------------------------------
// crd_pkg
// Shared constants, types and the byte-wide CRC-32 update for the checked
// record decoder.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int SCORE_SLOTS  = 12;
  localparam int RECORD_BYTES = 64;

  localparam int POS_W  = $clog2(RECORD_BYTES);
  localparam int SLOT_W = 4;
  localparam int VOL_W  = 4;
  localparam int RAM_AW = SLOT_W + 1;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [POS_W-1:0] CRC_SPAN   = POS_W'(60);
  localparam logic [POS_W-1:0] SCORE_BASE = POS_W'(9);
  localparam logic [POS_W-1:0] SCORE_END  = POS_W'(9 + 4 * SCORE_SLOTS);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(RECORD_BYTES - 1);
  localparam logic [POS_W-1:0] POS_VER    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_MUSIC  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_SOUND  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_VOLUME = POS_W'(8);

  localparam logic [7:0]        VOLUME_MAX = 8'd10;
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SCORE_SLOTS - 1);

  // Register indexes, decoded from paddr[2].
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
  } cfg_t;

  // Header fields of one finished record, handed to the result drain.
  typedef struct packed {
    logic             ok;
    logic             music;
    logic             sound;
    logic [VOL_W-1:0] volume;
    logic             bank;
  } record_sum_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/crd_byte_if.sv]
// ----------------------------------------------------------------------------
// crd_byte_if
// Byte stream channel: one record byte per transfer.
// ----------------------------------------------------------------------------
interface crd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
  modport monitor (input valid, input data_byte, input ready);
endinterface

[rtl/crd_result_if.sv]
// ----------------------------------------------------------------------------
// crd_result_if
// Result channel: one decoded score slot per transfer.
// ----------------------------------------------------------------------------
interface crd_result_if;
  logic                             valid;
  logic                             ready;
  logic                             record_ok;
  logic                             music_en;
  logic                             sound_en;
  logic [crd_pkg::VOL_W-1:0]        volume;
  logic [crd_pkg::SLOT_W-1:0]       slot;
  logic signed [31:0]               score;
  logic                             last_of_run;

  modport source (output valid, output record_ok, output music_en, output sound_en,
                  output volume, output slot, output score, output last_of_run,
                  input ready);
  modport sink (input valid, input record_ok, input music_en, input sound_en,
                input volume, input slot, input score, input last_of_run,
                output ready);
  modport monitor (input valid, input record_ok, input music_en, input sound_en,
                   input volume, input slot, input score, input last_of_run,
                   input ready);
endinterface

[rtl/checked_record_decoder.sv]
// ----------------------------------------------------------------------------
// checked_record_decoder
// Decodes CRC-checked 64-byte settings records into per-slot score results.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle with no gaps needed. After the 64th byte of a
// record the block delivers 12 results, one per cycle while the sink is
// ready, read from a double-banked score RAM through its single read port.
// The next record's bytes stream in meanwhile; only its final byte is held
// off while results of the previous record are still waiting. There is no
// clearing pass after reset. The expected magic and version registers sit at
// byte addresses 0 and 4.
module checked_record_decoder (
  input  logic                       clk,
  input  logic                       rst,
  crd_byte_if.sink                   byte_stream,
  crd_result_if.source               results,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  crd_pkg::cfg_t                cfg;
  crd_pkg::record_sum_t         summary;
  logic                         start;
  logic                         drain_busy;
  logic                         wr_en;
  logic [crd_pkg::RAM_AW-1:0]   wr_addr;
  logic [31:0]                  wr_data;
  logic                         rd_en;
  logic [crd_pkg::RAM_AW-1:0]   rd_addr;
  logic [31:0]                  rd_data;

  crd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .cfg         (cfg),
    .drain_busy  (drain_busy),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .start       (start),
    .summary     (summary)
  );

  crd_score_ram #(
    .AW (crd_pkg::RAM_AW),
    .DW (crd_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  crd_drain u_drain (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .summary (summary),
    .busy    (drain_busy),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .results (results)
  );

endmodule

[rtl/crd_score_ram.sv]
// ----------------------------------------------------------------------------
// crd_score_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crd_score_ram #(
  parameter int AW = 5,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/crd_cfg.sv]
// ----------------------------------------------------------------------------
// crd_cfg
// APB register file holding the expected magic word and format version.
// ----------------------------------------------------------------------------
module crd_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output crd_pkg::cfg_t              cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (paddr[2])
        crd_pkg::REG_MAGIC:   cfg.magic   <= pwdata;
        crd_pkg::REG_VERSION: cfg.version <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      crd_pkg::REG_MAGIC:   prdata = cfg.magic;
      crd_pkg::REG_VERSION: prdata = {16'd0, cfg.version};
      default:              prdata = '0;
    endcase
  end

endmodule

[rtl/crd_front.sv]
// ----------------------------------------------------------------------------
// crd_front
// Byte parser: tracks the position in the record, runs the CRC, captures
// the header and writes each completed score word into the score RAM.
// ----------------------------------------------------------------------------
module crd_front (
  input  logic                         clk,
  input  logic                         rst,
  crd_byte_if.sink                     byte_stream,
  input  crd_pkg::cfg_t                cfg,
  input  logic                         drain_busy,
  output logic                         wr_en,
  output logic [crd_pkg::RAM_AW-1:0]   wr_addr,
  output logic [31:0]                  wr_data,
  output logic                         start,
  output crd_pkg::record_sum_t         summary
);

  logic [crd_pkg::POS_W-1:0] pos;
  logic [crd_pkg::POS_W-1:0] rel;
  logic [31:0]               crc;
  logic [31:0]               magic;
  logic [15:0]               version;
  logic [23:0]               check_sr;
  logic [23:0]               score_sr;
  logic [1:0]                flags;
  logic [7:0]                raw_vol;
  logic                      bank;
  logic                      accept;
  logic                      in_scores;
  logic                      ok;
  logic [crd_pkg::VOL_W-1:0] vol_clamped;
  logic [7:0]                b;

  assign b = byte_stream.data_byte;

  // The final byte of a record waits until the previous record's results
  // have all gone out, since it hands a new summary to the drain.
  assign byte_stream.ready = !(pos == crd_pkg::LAST_POS && drain_busy);
  assign accept            = byte_stream.valid && byte_stream.ready;

  assign rel       = pos - crd_pkg::SCORE_BASE;
  assign in_scores = (pos >= crd_pkg::SCORE_BASE) && (pos < crd_pkg::SCORE_END);

  // A score word is complete on its fourth byte; it is written whole.
  assign wr_en   = accept && in_scores && (rel[1:0] == 2'b11);
  assign wr_addr = {bank, rel[2 +: crd_pkg::SLOT_W]};
  assign wr_data = {score_sr, b};

  assign ok = (magic == cfg.magic) && (version == cfg.version) &&
              ({check_sr, b} == ~crc);
  assign vol_clamped = (raw_vol > crd_pkg::VOLUME_MAX) ?
                       crd_pkg::VOL_W'(crd_pkg::VOLUME_MAX) : raw_vol[crd_pkg::VOL_W-1:0];

  assign start          = accept && (pos == crd_pkg::LAST_POS);
  assign summary.ok     = ok;
  assign summary.music  = ok && flags[0];
  assign summary.sound  = ok && flags[1];
  assign summary.volume = ok ? vol_clamped : '0;
  assign summary.bank   = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      crc  <= crd_pkg::CRC_INIT;
      bank <= 1'b0;
    end else if (accept) begin
      if (pos == crd_pkg::LAST_POS) begin
        pos  <= '0;
        crc  <= crd_pkg::CRC_INIT;
        bank <= !bank;
      end else begin
        pos <= pos + 1'b1;
        if (pos < crd_pkg::CRC_SPAN) begin
          crc <= crd_pkg::crc_byte(crc, b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos < crd_pkg::POS_VER) begin
        magic <= {magic[23:0], b};
      end else if (pos < crd_pkg::POS_MUSIC) begin
        version <= {version[7:0], b};
      end else if (pos == crd_pkg::POS_MUSIC) begin
        flags[0] <= (b != 8'd0);
      end else if (pos == crd_pkg::POS_SOUND) begin
        flags[1] <= (b != 8'd0);
      end else if (pos == crd_pkg::POS_VOLUME) begin
        raw_vol <= b;
      end else if (in_scores) begin
        score_sr <= {score_sr[15:0], b};
      end else if (pos >= crd_pkg::CRC_SPAN) begin
        check_sr <= {check_sr[15:0], b};
      end
    end
  end

endmodule

[rtl/crd_drain.sv]
// ----------------------------------------------------------------------------
// crd_drain
// Result sequencer: reads the score slots of a finished record from the
// score RAM and presents one result per slot.
// ----------------------------------------------------------------------------
module crd_drain (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  crd_pkg::record_sum_t         summary,
  output logic                         busy,
  output logic                         rd_en,
  output logic [crd_pkg::RAM_AW-1:0]   rd_addr,
  input  logic [31:0]                  rd_data,
  crd_result_if.source                 results
);

  crd_pkg::record_sum_t       sum;
  logic                       active;
  logic [crd_pkg::SLOT_W-1:0] rd_slot;
  logic                       out_valid;
  logic [crd_pkg::SLOT_W-1:0] out_slot;
  logic                       out_last;

  // The RAM read data register doubles as the score output register, so a
  // read is issued only when the shown result leaves or none is shown.
  assign rd_en   = active && (!out_valid || results.ready);
  assign rd_addr = {sum.bank, rd_slot};
  assign busy    = active || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        active  <= 1'b1;
        rd_slot <= '0;
        sum     <= summary;
      end else if (rd_en) begin
        rd_slot <= rd_slot + 1'b1;
        if (rd_slot == crd_pkg::LAST_SLOT) begin
          active <= 1'b0;
        end
      end
      if (rd_en) begin
        out_valid <= 1'b1;
        out_slot  <= rd_slot;
        out_last  <= (rd_slot == crd_pkg::LAST_SLOT);
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.record_ok   = sum.ok;
  assign results.music_en    = sum.music;
  assign results.sound_en    = sum.sound;
  assign results.volume      = sum.volume;
  assign results.slot        = out_slot;
  assign results.score       = sum.ok ? rd_data : 32'd0;
  assign results.last_of_run = out_last;

endmodule

[rtl/crd_checker.sv]
// ----------------------------------------------------------------------------
// crd_checker
// Port-level checks on the result channel of the checked record decoder.
// ----------------------------------------------------------------------------
module crd_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  input  logic                       ready,
  input  logic                       record_ok,
  input  logic                       music_en,
  input  logic                       sound_en,
  input  logic [crd_pkg::VOL_W-1:0]  volume,
  input  logic [crd_pkg::SLOT_W-1:0] slot,
  input  logic signed [31:0]         score,
  input  logic                       last_of_run
);

  // A stalled result stays valid with its slot and score unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(slot) && $stable(score))
    else $error("result changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last_of_run == (slot == crd_pkg::LAST_SLOT)))
    else $error("last_of_run does not match the final slot");

  // A failed record carries no settings or scores.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !record_ok |->
      score == 32'sd0 && volume == '0 && !music_en && !sound_en)
    else $error("failed record shows nonzero fields");

  a_volume: assert property (@(posedge clk) disable iff (rst)
    valid |-> volume <= crd_pkg::VOL_W'(crd_pkg::VOLUME_MAX))
    else $error("volume above its clamp");

  // Within a record, the result after a transfer is the next slot.
  a_slot_seq: assert property (@(posedge clk) disable iff (rst)
    valid && ready && !last_of_run |=>
      !valid || (slot == $past(slot) + 1'b1))
    else $error("slot sequence broken");

endmodule

bind checked_record_decoder crd_checker u_crd_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (results.valid),
  .ready       (results.ready),
  .record_ok   (results.record_ok),
  .music_en    (results.music_en),
  .sound_en    (results.sound_en),
  .volume      (results.volume),
  .slot        (results.slot),
  .score       (results.score),
  .last_of_run (results.last_of_run)
);
